[sv/sosc_pkg.sv]
package sosc_pkg;

  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int SINE_N     = 1 << SINE_TABLE_BITS;
  localparam int IDX_LSB    = PHASE_BITS - SINE_TABLE_BITS - 2;
  localparam int HELD_SHIFT = 31 - SAMPLE_BITS;
  localparam int Q15_SHIFT  = 15;

  localparam int FREQ_W  = 24;
  localparam int VOL_W   = 16;
  localparam int TGT_W   = 23;
  localparam int TAB_W   = 15;
  localparam int SINE_W  = TAB_W + 1;
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int F_W     = 26;
  localparam int G_W     = 19;
  localparam int V_W     = 20;

  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  typedef enum logic [2:0] {
    REG_MODE          = 3'd0,
    REG_TARGET_FREQ   = 3'd1,
    REG_TARGET_VOLUME = 3'd2,
    REG_SLEW_STEPS    = 3'd3,
    REG_FM_RATE       = 3'd4,
    REG_FM_DEPTH      = 3'd5,
    REG_AM_RATE       = 3'd6,
    REG_AM_DEPTH      = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SLEW, OP_PHASE, OP_RD_FM, OP_MUL_FM, OP_F, OP_MUL_AM,
    OP_G, OP_MUL_V, OP_V, OP_RD_C, OP_MUL_OUT, OP_HOLD, OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [TGT_W-1:0]  carrier_inc;
    logic [VOL_W-1:0]  target_volume;
    logic [FREQ_W-1:0] fstep;
    logic [VOL_W-1:0]  vstep;
    logic [TGT_W-1:0]  fm_rate;
    logic [TGT_W-1:0]  fm_depth;
    logic [TGT_W-1:0]  am_rate;
    logic [VOL_W-1:0]  am_depth;
  } cfg_t;

  typedef struct packed {
    logic adv;
    logic out_free;
  } dp_stat_t;

  typedef logic [TAB_W-1:0] sine_tab_t [SINE_N];

  function automatic logic [TAB_W-1:0] quarter_entry(input longint unsigned i);
    longint unsigned th, t2, r, s;
    th = ((2 * i + 1) * 64'd1686629713) >> (SINE_TABLE_BITS + 1);
    t2 = (th * th) >> 30;
    r  = (64'd1 << 30) - t2 / 110;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 72;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 42;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 20;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 6;
    s  = (th * r) >> 30;
    return TAB_W'((s * 32767 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int k = 0; k < SINE_N; k++) begin
      t[k] = quarter_entry(longint'(k));
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic [FREQ_W-1:0] slew(input logic [FREQ_W-1:0] cur,
                                              input logic [FREQ_W-1:0] tgt,
                                              input logic [FREQ_W-1:0] step);
    logic [FREQ_W-1:0] res;
    if (cur < tgt) begin
      res = ((tgt - cur) > step) ? cur + step : tgt;
    end else begin
      res = ((cur - tgt) > step) ? cur - step : tgt;
    end
    return res;
  endfunction

  function automatic logic signed [PROD_W-1:0] trunc_shift(
      input logic signed [PROD_W-1:0] x, input int sh);
    logic signed [PROD_W-1:0] bias;
    bias = (PROD_W'(1) << sh) - PROD_W'(1);
    return x[PROD_W-1] ? ((x + bias) >>> sh) : (x >>> sh);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi, lo;
    logic signed [SAMPLE_BITS-1:0] res;
    hi = (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - PROD_W'(1);
    lo = -hi - PROD_W'(1);
    if (x > hi) begin
      res = hi[SAMPLE_BITS-1:0];
    end else if (x < lo) begin
      res = lo[SAMPLE_BITS-1:0];
    end else begin
      res = x[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

[sv/sosc_ctrl.sv]
module sosc_ctrl import sosc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  typedef enum logic [13:0] {
    ST_IDLE    = 14'h0001,
    ST_SLEW    = 14'h0002,
    ST_PHASE   = 14'h0004,
    ST_RD_FM   = 14'h0008,
    ST_MUL_FM  = 14'h0010,
    ST_F       = 14'h0020,
    ST_MUL_AM  = 14'h0040,
    ST_G       = 14'h0080,
    ST_MUL_V   = 14'h0100,
    ST_V       = 14'h0200,
    ST_RD_C    = 14'h0400,
    ST_MUL_OUT = 14'h0800,
    ST_HOLD    = 14'h1000,
    ST_OUT     = 14'h2000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_SLEW;
        end
      end
      ST_SLEW: begin
        if (stat_i.adv) begin
          op_o    = OP_SLEW;
          state_d = ST_PHASE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_PHASE: begin
        op_o    = OP_PHASE;
        state_d = ST_RD_FM;
      end
      ST_RD_FM: begin
        op_o    = OP_RD_FM;
        state_d = ST_MUL_FM;
      end
      ST_MUL_FM: begin
        op_o    = OP_MUL_FM;
        state_d = ST_F;
      end
      ST_F: begin
        op_o    = OP_F;
        state_d = ST_MUL_AM;
      end
      ST_MUL_AM: begin
        op_o    = OP_MUL_AM;
        state_d = ST_G;
      end
      ST_G: begin
        op_o    = OP_G;
        state_d = ST_MUL_V;
      end
      ST_MUL_V: begin
        op_o    = OP_MUL_V;
        state_d = ST_V;
      end
      ST_V: begin
        op_o    = OP_V;
        state_d = ST_RD_C;
      end
      ST_RD_C: begin
        op_o    = OP_RD_C;
        state_d = ST_MUL_OUT;
      end
      ST_MUL_OUT: begin
        op_o    = OP_MUL_OUT;
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        op_o    = OP_HOLD;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          op_o    = OP_OUT;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/sosc_dp.sv]
module sosc_dp import sosc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          restart_i,
  input  dp_op_e                        op_i,
  input  logic signed [SAMPLE_BITS-1:0] mix_in_i,
  input  logic                          new_sample_i,
  output dp_stat_t                      stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] mix_out_o
);

  logic [PHASE_BITS-1:0] carrier_q, fm_ph_q, am_ph_q;
  logic [FREQ_W-1:0]     freq_now_q, fmr_now_q, fmd_now_q, amr_now_q;
  logic [VOL_W-1:0]      vol_now_q, amd_now_q;
  logic signed [SAMPLE_BITS-1:0] held_q, mix_q, mix_out_q;
  logic                  new_q, out_valid_q;

  logic [TAB_W-1:0]          rom_q;
  logic                      neg_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [F_W-1:0]     f_q;
  logic signed [G_W-1:0]     g_q;
  logic signed [V_W-1:0]     v_q;

  logic [PHASE_BITS-1:0]      rom_phase;
  logic [SINE_TABLE_BITS+1:0] rom_idx;
  logic [SINE_TABLE_BITS-1:0] rom_pos;
  logic signed [SINE_W-1:0]   sine;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_tr, mix_sum;
  logic fm_on, am_on, out_on;

  assign out_on = cfg_i.mode[0];
  assign fm_on  = cfg_i.mode[1];
  assign am_on  = cfg_i.mode[2];

  assign stat_o.adv      = out_on & new_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign mix_out_o       = mix_out_q;

  // sine table addressing with quadrant folding
  always_comb begin
    case (op_i)
      OP_RD_FM:  rom_phase = fm_ph_q;
      OP_MUL_FM: rom_phase = am_ph_q;
      default:   rom_phase = carrier_q;
    endcase
  end
  assign rom_idx = rom_phase[PHASE_BITS-1:IDX_LSB];
  assign rom_pos = rom_idx[SINE_TABLE_BITS] ? ~rom_idx[SINE_TABLE_BITS-1:0]
                                            : rom_idx[SINE_TABLE_BITS-1:0];
  assign sine    = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  // shared multiplier operands
  always_comb begin
    case (op_i)
      OP_MUL_FM: begin
        mul_a = MUL_A_W'(sine);
        mul_b = $signed({1'b0, fmd_now_q});
      end
      OP_MUL_AM: begin
        mul_a = MUL_A_W'(sine);
        mul_b = $signed(MUL_B_W'(amd_now_q));
      end
      OP_MUL_V: begin
        mul_a = $signed({1'b0, vol_now_q});
        mul_b = MUL_B_W'(g_q);
      end
      default: begin
        mul_a = MUL_A_W'(sine);
        mul_b = MUL_B_W'(v_q);
      end
    endcase
  end

  assign prod_tr = trunc_shift(prod_q, Q15_SHIFT);
  assign mix_sum = PROD_W'(mix_q) + PROD_W'(held_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q   <= '0;
      fm_ph_q     <= '0;
      am_ph_q     <= '0;
      freq_now_q  <= '0;
      vol_now_q   <= '0;
      fmr_now_q   <= '0;
      fmd_now_q   <= '0;
      amr_now_q   <= '0;
      amd_now_q   <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (restart_i) begin
        freq_now_q <= FREQ_W'(cfg_i.carrier_inc);
        vol_now_q  <= cfg_i.target_volume;
        fmr_now_q  <= FREQ_W'(cfg_i.fm_rate);
        fmd_now_q  <= FREQ_W'(cfg_i.fm_depth);
        amr_now_q  <= FREQ_W'(cfg_i.am_rate);
        amd_now_q  <= cfg_i.am_depth;
        carrier_q  <= '0;
        fm_ph_q    <= '0;
        am_ph_q    <= '0;
        held_q     <= '0;
      end else begin
        case (op_i)
          OP_SLEW: begin
            freq_now_q <= slew(freq_now_q, FREQ_W'(cfg_i.carrier_inc), cfg_i.fstep);
            vol_now_q  <= VOL_W'(slew(FREQ_W'(vol_now_q), FREQ_W'(cfg_i.target_volume),
                                      FREQ_W'(cfg_i.vstep)));
            if (fm_on) begin
              fmr_now_q <= slew(fmr_now_q, FREQ_W'(cfg_i.fm_rate), cfg_i.fstep);
              fmd_now_q <= slew(fmd_now_q, FREQ_W'(cfg_i.fm_depth), cfg_i.fstep);
            end
            if (am_on) begin
              amr_now_q <= slew(amr_now_q, FREQ_W'(cfg_i.am_rate), cfg_i.fstep);
              amd_now_q <= VOL_W'(slew(FREQ_W'(amd_now_q), FREQ_W'(cfg_i.am_depth),
                                       FREQ_W'(cfg_i.vstep)));
            end
          end
          OP_PHASE: begin
            if (fm_on) begin
              fm_ph_q <= fm_ph_q + PHASE_BITS'(fmr_now_q);
            end
            if (am_on) begin
              am_ph_q <= am_ph_q + PHASE_BITS'(amr_now_q);
            end
          end
          OP_V: begin
            carrier_q <= carrier_q + PHASE_BITS'(f_q);
          end
          OP_HOLD: begin
            held_q <= sat_sample(trunc_shift(prod_q, HELD_SHIFT));
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        mix_q <= mix_in_i;
        new_q <= new_sample_i;
      end
      OP_RD_FM, OP_RD_C: begin
        rom_q <= SINE_TAB[rom_pos];
        neg_q <= rom_idx[SINE_TABLE_BITS+1];
      end
      OP_MUL_FM: begin
        prod_q <= mul_a * mul_b;
        rom_q  <= SINE_TAB[rom_pos];
        neg_q  <= rom_idx[SINE_TABLE_BITS+1];
      end
      OP_MUL_AM, OP_MUL_V, OP_MUL_OUT: begin
        prod_q <= mul_a * mul_b;
      end
      OP_F: begin
        f_q <= $signed(F_W'(freq_now_q)) + (fm_on ? F_W'(prod_tr) : F_W'(0));
      end
      OP_G: begin
        g_q <= G_W'(32768) + G_W'(prod_tr);
      end
      OP_V: begin
        v_q <= am_on ? V_W'(prod_tr) : $signed(V_W'(vol_now_q));
      end
      OP_OUT: begin
        mix_out_q <= out_on ? sat_sample(mix_sum) : mix_q;
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/sine_oscillator_fm_am_glide_core.sv]
// sine oscillator with fm, am and parameter glide, mixed into an audio stream
// input channel: in_valid_i/in_ready_o carry mix_in_i and new_sample_i, one
//   channel sample per transaction; new_sample_i marks the first channel of a frame
// output channel: out_valid_o/out_ready_i carry mix_out_o, one per input
// config: apb-style write/read port, 64-bit data, register i at byte 8*i;
//   writing mode snaps all live values to targets and clears the phases
// steps: a frame-start item with output enabled runs slew, phase, the fm and
//   am multiplies, the volume multiply, carrier advance, carrier read, output
//   multiply and hold before its result is loaded into the output register;
//   any other item goes straight from the slew check to the output step
// one item in flight: the next is accepted only after the current result is loaded;
//   the steps run through one shared multiplier and one registered sine table read
// a waiting result does not block the next accept; if out_ready_i stays low
//   the next item stalls before its own result is loaded
// reset: all targets, live values, phases and held value clear to zero
module sine_oscillator_fm_am_glide_core import sosc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_AW-1:0]             paddr,
  input  logic [CFG_DW-1:0]             pwdata,
  output logic [CFG_DW-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] mix_in_i,
  input  logic                          new_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] mix_out_o
);

  cfg_t     cfg_q;
  dp_stat_t stat;
  dp_op_e   op;
  reg_idx_e idx;
  logic     wr_en, restart;

  assign pready  = 1'b1;
  assign idx     = reg_idx_e'(paddr[CFG_AW-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && (idx == REG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:          cfg_q.mode          <= pwdata[2:0];
        REG_TARGET_FREQ:   cfg_q.carrier_inc   <= pwdata[TGT_W-1:0];
        REG_TARGET_VOLUME: cfg_q.target_volume <= pwdata[VOL_W-1:0];
        REG_SLEW_STEPS: begin
          cfg_q.fstep <= pwdata[FREQ_W-1:0];
          cfg_q.vstep <= pwdata[FREQ_W+VOL_W-1:FREQ_W];
        end
        REG_FM_RATE:       cfg_q.fm_rate       <= pwdata[TGT_W-1:0];
        REG_FM_DEPTH:      cfg_q.fm_depth      <= pwdata[TGT_W-1:0];
        REG_AM_RATE:       cfg_q.am_rate       <= pwdata[TGT_W-1:0];
        REG_AM_DEPTH:      cfg_q.am_depth      <= pwdata[VOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:          prdata = CFG_DW'(cfg_q.mode);
      REG_TARGET_FREQ:   prdata = CFG_DW'(cfg_q.carrier_inc);
      REG_TARGET_VOLUME: prdata = CFG_DW'(cfg_q.target_volume);
      REG_SLEW_STEPS:    prdata = CFG_DW'({cfg_q.vstep, cfg_q.fstep});
      REG_FM_RATE:       prdata = CFG_DW'(cfg_q.fm_rate);
      REG_FM_DEPTH:      prdata = CFG_DW'(cfg_q.fm_depth);
      REG_AM_RATE:       prdata = CFG_DW'(cfg_q.am_rate);
      REG_AM_DEPTH:      prdata = CFG_DW'(cfg_q.am_depth);
      default:           prdata = '0;
    endcase
  end

  sosc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  sosc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .restart_i    (restart),
    .op_i         (op),
    .mix_in_i     (mix_in_i),
    .new_sample_i (new_sample_i),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mix_out_o    (mix_out_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accept did not leave idle");

  a_idle_no_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !in_valid_i) |-> (op == OP_NONE))
    else $error("datapath step issued while idle");
`endif

endmodule

[bench/sine_oscillator_fm_am_glide_checker.sv]
module sine_oscillator_fm_am_glide_checker import sosc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_AW-1:0]             paddr,
  input  logic [CFG_DW-1:0]             pwdata,
  input  logic                          pready,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] mix_in_i,
  input  logic                          new_sample_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] mix_out_o,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0]  osc_mode;
  logic [22:0] tgt_freq, tgt_fm_rate, tgt_fm_depth, tgt_am_rate;
  logic [15:0] tgt_volume, tgt_am_depth;
  logic [39:0] glide_steps;

  logic [23:0] carrier_ph, fm_ph, am_ph;
  logic [23:0] freq_live, fm_rate_live, fm_depth_live, am_rate_live;
  logic [15:0] volume_live, am_depth_live;
  longint      held_sample;

  logic signed [SAMPLE_BITS-1:0] mix_expected[$];
  logic [14:0] sine_rom [1024];

  function automatic longint unsigned rom_entry(input longint unsigned i);
    longint unsigned th, t2, r, s;
    th = ((2 * i + 1) * 64'd1686629713) >> 11;
    t2 = (th * th) >> 30;
    r  = (64'd1 << 30) - t2 / 110;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 72;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 42;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 20;
    r  = (64'd1 << 30) - ((t2 * r) >> 30) / 6;
    s  = (th * r) >> 30;
    return (s * 32767 + (64'd1 << 29)) >> 30;
  endfunction

  initial begin
    for (int k = 0; k < 1024; k++) sine_rom[k] = 15'(rom_entry(k));
  end

  function automatic longint sine_at(input logic [23:0] ph);
    logic [1:0] quad;
    logic [9:0] idx;
    longint     v;
    quad = ph[23:22];
    idx  = quad[0] ? 10'(1023 - ph[21:12]) : ph[21:12];
    v    = longint'(sine_rom[idx]);
    return quad[1] ? -v : v;
  endfunction

  function automatic logic [23:0] glide(input logic [23:0] cur, input logic [23:0] tgt,
                                         input logic [23:0] step);
    if (cur < tgt) return ((tgt - cur) > step) ? cur + step : tgt;
    return ((cur - tgt) > step) ? cur - step : tgt;
  endfunction

  function automatic longint clamp16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  task automatic restart_osc();
    freq_live     = 24'(tgt_freq);
    volume_live   = tgt_volume;
    fm_rate_live  = 24'(tgt_fm_rate);
    fm_depth_live = 24'(tgt_fm_depth);
    am_rate_live  = 24'(tgt_am_rate);
    am_depth_live = tgt_am_depth;
    carrier_ph = '0;
    fm_ph      = '0;
    am_ph      = '0;
    held_sample = 0;
  endtask

  task automatic advance_osc();
    logic [23:0] fstep;
    logic [23:0] vstep;
    longint      f, v, g;
    fstep = glide_steps[23:0];
    vstep = 24'(glide_steps[39:24]);
    freq_live   = glide(freq_live, 24'(tgt_freq), fstep);
    volume_live = 16'(glide(24'(volume_live), 24'(tgt_volume), vstep));
    f = longint'(freq_live);
    v = longint'(volume_live);
    if (osc_mode[1]) begin
      fm_rate_live  = glide(fm_rate_live, 24'(tgt_fm_rate), fstep);
      fm_depth_live = glide(fm_depth_live, 24'(tgt_fm_depth), fstep);
      fm_ph = fm_ph + fm_rate_live;
      f += (sine_at(fm_ph) * longint'(fm_depth_live)) / 32768;
    end
    if (osc_mode[2]) begin
      am_rate_live  = glide(am_rate_live, 24'(tgt_am_rate), fstep);
      am_depth_live = 16'(glide(24'(am_depth_live), 24'(tgt_am_depth), vstep));
      am_ph = am_ph + am_rate_live;
      g = 32768 + (sine_at(am_ph) * longint'(am_depth_live)) / 32768;
      v = (v * g) / 32768;
    end
    carrier_ph = carrier_ph + 24'(f);
    held_sample = clamp16((sine_at(carrier_ph) * v) / 32768);
  endtask

  assign pending_count = mix_expected.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_ni) begin
      osc_mode = '0; tgt_freq = '0; tgt_volume = '0; glide_steps = '0;
      tgt_fm_rate = '0; tgt_fm_depth = '0; tgt_am_rate = '0; tgt_am_depth = '0;
      restart_osc();
      mix_expected.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[5:3]))
          REG_MODE: begin
            osc_mode = pwdata[2:0];
            restart_osc();
          end
          REG_TARGET_FREQ:   tgt_freq     = pwdata[22:0];
          REG_TARGET_VOLUME: tgt_volume   = pwdata[15:0];
          REG_SLEW_STEPS:    glide_steps  = pwdata[39:0];
          REG_FM_RATE:       tgt_fm_rate  = pwdata[22:0];
          REG_FM_DEPTH:      tgt_fm_depth = pwdata[22:0];
          REG_AM_RATE:       tgt_am_rate  = pwdata[22:0];
          REG_AM_DEPTH:      tgt_am_depth = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (mix_expected.size() == 0) begin
          $display("%0t: unexpected mix_out transaction, actual %0d", $realtime, mix_out_o);
          fail_count++;
        end else begin
          want = mix_expected.pop_front();
          if (mix_out_o !== want) begin
            $display("%0t: mix_out mismatch, expected %0d actual %0d",
                     $realtime, want, mix_out_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (!osc_mode[0]) begin
          mix_expected.push_back(mix_in_i);
        end else begin
          if (new_sample_i) advance_osc();
          mix_expected.push_back(16'(clamp16(longint'(mix_in_i) + held_sample)));
        end
      end
    end
  end
endmodule

[bench/sine_oscillator_fm_am_glide_core_tb.sv]
module sine_oscillator_fm_am_glide_core_tb;
  import sosc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SAMPLE_BITS-1:0] mix_in_i = '0;
  logic new_sample_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] mix_out_o;
  int fail_count, pending_count;

  int send_idle_pct = 8, recv_idle_pct = 62;
  bit hold_off = 1'b0;
  int cycle_count = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sine_oscillator_fm_am_glide_core u_dut (.*);

  sine_oscillator_fm_am_glide_checker u_chk (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    repeat (400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= CFG_AW'(idx) << 3;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [15:0] smp, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mix_in_i     <= smp;
    new_sample_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_frames(input int count);
    int chans;
    logic [15:0] smp;
    for (int n = 0; n < count;) begin
      chans = $urandom_range(1, 4);
      for (int c = 0; c < chans && n < count; c++, n++) begin
        case ($urandom_range(7))
          0: smp = 16'h7fff;
          1: smp = 16'h8000;
          default: smp = 16'($urandom);
        endcase
        send_sample(smp, (c == 0) ? 1'b1 : ($urandom_range(19) == 0));
      end
    end
  endtask

  task automatic random_config();
    write_reg(REG_TARGET_FREQ, 64'($urandom_range(0, 23'h7fffff)));
    write_reg(REG_TARGET_VOLUME, 64'($urandom_range(0, 16'hffff)));
    write_reg(REG_SLEW_STEPS, {24'd0, 8'($urandom), 32'($urandom)});
    write_reg(REG_FM_RATE, 64'($urandom_range(0, 23'h7fffff)));
    write_reg(REG_FM_DEPTH, 64'($urandom_range(0, 23'h7fffff)));
    write_reg(REG_AM_RATE, 64'($urandom_range(0, 23'h7fffff)));
    write_reg(REG_AM_DEPTH, 64'($urandom_range(0, 16'hffff)));
    write_reg(REG_MODE, 64'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // output disabled, then all on at extremes
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b0);
    drain();
    write_reg(REG_TARGET_FREQ, 64'h7fffff);
    write_reg(REG_TARGET_VOLUME, 64'hffff);
    write_reg(REG_SLEW_STEPS, 64'hff_ffff_ffff);
    write_reg(REG_FM_RATE, 64'h7fffff);
    write_reg(REG_FM_DEPTH, 64'h7fffff);
    write_reg(REG_AM_RATE, 64'h7fffff);
    write_reg(REG_AM_DEPTH, 64'hffff);
    write_reg(REG_MODE, 64'd7);
    for (int k = 0; k < 8; k++) begin
      send_sample((k & 1) ? 16'h8000 : 16'h7fff, 1'b1);
      send_sample(16'h0000, 1'b0);
    end
    drain();
    // glide from snapped values toward new targets with small steps
    write_reg(REG_TARGET_FREQ, 64'h123456);
    write_reg(REG_TARGET_VOLUME, 64'h4000);
    write_reg(REG_SLEW_STEPS, {24'd0, 16'h0100, 24'h001000});
    write_reg(REG_AM_DEPTH, 64'h8000);
    for (int k = 0; k < 6; k++) send_sample(16'($urandom), 1'b1);
    drain();
    write_reg(REG_MODE, 64'd1);
    write_reg(REG_MODE, 64'd1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hffff, 1'b0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 8 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        random_config();
        send_frames(170);
        drain();
      end
    end
    write_reg(REG_MODE, 64'd0);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
